[rtl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/zcns_pkg.sv]
// types, constants and saturation helpers for the zener clipper solver
// no dependencies
`default_nettype none
package zcns_pkg;

	localparam int SAMPLE_W = 24;
	localparam int COEFF_W  = 17;
	localparam int ITER_W   = 5;
	localparam int MUL_W    = 34;
	localparam int PROD_W   = 68;
	localparam int WIDE_W   = 40;
	localparam int DIVD_W   = 64;
	localparam int DIVS_W   = 40;
	localparam int QUO_W    = 31;

	localparam logic [ITER_W-1:0]  ITER_RESET = 5'd8;
	localparam logic [COEFF_W-1:0] A_MAX      = 17'd65536;

	localparam logic signed [MUL_W-1:0] K_BETA_EXP    = 34'sd2527337;
	localparam logic signed [MUL_W-1:0] K_BETA_EXP_10 = 34'sd252734;
	localparam logic signed [MUL_W-1:0] K_OFFSET      = 34'sd3727243;
	localparam logic signed [MUL_W-1:0] K_KNEE        = 34'sd137573171;
	localparam logic signed [MUL_W-1:0] K_SCALE       = 34'sd1660944;
	localparam logic signed [MUL_W-1:0] K_SLOPE       = 34'sd16609444;
	localparam logic signed [31:0]      K_LIMIT       = 32'sd125829120;
	localparam logic signed [WIDE_W-1:0] Q24_ONE      = 40'sd16777216;
	localparam logic signed [WIDE_W-1:0] NUM_C0       = 40'sd110100480;
	localparam logic signed [WIDE_W-1:0] DEN_C0       = 40'sd142868480;

	typedef enum logic [4:0] {
		OP_NOP, OP_LOAD, OP_UMUL, OP_U, OP_V, OP_LMUL, OP_LIN, OP_W, OP_TMUL, OP_T,
		OP_S2MUL, OP_S2, OP_S3MUL, OP_S3, OP_S4MUL, OP_S4, OP_ND, OP_DIV1, OP_KMUL,
		OP_F, OP_FPMUL, OP_FP, OP_DIV2, OP_Y, OP_OUT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic ch;
	} dp_cmd_t;

	typedef struct packed {
		logic linear;
		logic div_busy;
	} dp_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] x);
		if (x > 40'sd2147483647) return 32'sh7fffffff;
		else if (x < -40'sd2147483648) return 32'sh80000000;
		else return x[31:0];
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [WIDE_W-1:0] x);
		if (x > 40'sd8388607) return 24'sh7fffff;
		else if (x < -40'sd8388608) return 24'sh800000;
		else return x[SAMPLE_W-1:0];
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] negsat24(input logic signed [SAMPLE_W-1:0] y);
		if (y == 24'sh800000) return 24'sh7fffff;
		else return -y;
	endfunction

endpackage
`default_nettype wire

[rtl/zcns_div.sv]
// radix-2 restoring signed divider, truncating, quotient saturated to 32 bits
// uses zcns_pkg
`default_nettype none
module zcns_div (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic signed [zcns_pkg::DIVD_W-1:0]    dividend,
	input  wire logic        [zcns_pkg::DIVS_W-1:0]    divisor,
	output logic                                       busy,
	output logic signed [31:0]                         quotient
);
	import zcns_pkg::*;

	localparam int CNT_W = $clog2(QUO_W);
	localparam int SH_W  = DIVS_W + QUO_W - 1;
	localparam int OV_W  = DIVS_W + QUO_W;

	logic [DIVD_W-1:0] mag;
	logic              ovf;
	logic [DIVD_W-1:0] rem_q;
	logic [SH_W-1:0]   dsh_q;
	logic [QUO_W-1:0]  q_q;
	logic [QUO_W-1:0]  q_next;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;
	logic              busy_q;
	logic signed [31:0] res_q;
	logic              ge;

	assign mag    = dividend[DIVD_W-1] ? DIVD_W'(-dividend) : DIVD_W'(dividend);
	assign ovf    = OV_W'(mag) >= (OV_W'(divisor) << QUO_W);
	assign ge     = SH_W'(rem_q) >= dsh_q;
	assign q_next = {q_q[QUO_W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			neg_q <= dividend[DIVD_W-1];
			if (ovf) begin
				busy_q <= 1'b0;
				res_q  <= dividend[DIVD_W-1] ? 32'sh80000000 : 32'sh7fffffff;
			end else begin
				busy_q <= 1'b1;
				rem_q  <= mag;
				dsh_q  <= SH_W'(divisor) << (QUO_W - 1);
				q_q    <= '0;
				cnt_q  <= CNT_W'(QUO_W - 1);
			end
		end else if (busy_q) begin
			if (ge) rem_q <= rem_q - dsh_q[DIVD_W-1:0];
			dsh_q <= dsh_q >> 1;
			q_q   <= q_next;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				res_q  <= neg_q ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = res_q;
endmodule
`default_nettype wire

[rtl/zcns_datapath.sv]
// solver datapath: shared multiplier, working registers, estimates, output registers
// uses zcns_pkg and zcns_div
`default_nettype none
module zcns_datapath (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire zcns_pkg::dp_cmd_t                     cmd,
	output zcns_pkg::dp_sts_t                          sts,
	input  wire logic signed [zcns_pkg::SAMPLE_W-1:0]  sample_left,
	input  wire logic signed [zcns_pkg::SAMPLE_W-1:0]  sample_right,
	input  wire logic        [zcns_pkg::COEFF_W-1:0]   drive_coeff,
	output logic signed [zcns_pkg::SAMPLE_W-1:0]       out_left,
	output logic signed [zcns_pkg::SAMPLE_W-1:0]       out_right
);
	import zcns_pkg::*;

	logic signed [SAMPLE_W-1:0] xl_q, xr_q, x_sel;
	logic signed [SAMPLE_W-1:0] y_q [2];
	logic signed [SAMPLE_W-1:0] y_sel;
	logic        [COEFF_W-1:0]  a_q;
	logic signed [27:0]         x24, y24;
	logic signed [MUL_W-1:0]    a34;
	logic signed [MUL_W-1:0]    mul_a, mul_b;
	logic signed [PROD_W-1:0]   prod_q, p16, p24;
	logic signed [31:0]         u_q, v_q;
	logic signed [MUL_W-1:0]    w_q, s_q, s2_q, s3_q, f_q, fp_q, bigf_q;
	logic signed [WIDE_W-1:0]   s4_q, num_q, den_q, bigfp_q;
	logic signed [MUL_W-1:0]    wsum, mag;
	logic signed [WIDE_W-1:0]   tneg, num, den, bp, ysum;
	logic signed [SAMPLE_W-1:0] outl_q, outr_q;
	logic                       div_start, div_busy;
	logic signed [DIVD_W-1:0]   div_dividend;
	logic        [DIVS_W-1:0]   div_divisor;
	logic signed [31:0]         quo;

	assign x_sel = cmd.ch ? xr_q : xl_q;
	assign y_sel = cmd.ch ? y_q[1] : y_q[0];
	assign x24   = {x_sel, 4'b0};
	assign y24   = {y_sel, 4'b0};
	assign a34   = $signed({{(MUL_W-COEFF_W){1'b0}}, a_q});
	assign p16   = prod_q >>> 16;
	assign p24   = prod_q >>> 24;

	always_comb begin
		unique case (cmd.op)
			OP_UMUL:  begin mul_a = a34;               mul_b = MUL_W'(y24); end
			OP_LMUL:  begin mul_a = MUL_W'(v_q);       mul_b = K_SCALE;     end
			OP_TMUL:  begin mul_a = K_BETA_EXP;        mul_b = w_q;         end
			OP_S2MUL: begin mul_a = s_q;               mul_b = s_q;         end
			OP_S3MUL: begin mul_a = s2_q;              mul_b = s_q;         end
			OP_S4MUL: begin mul_a = s2_q;              mul_b = s2_q;        end
			OP_KMUL:  begin mul_a = K_KNEE - MUL_W'(quo); mul_b = K_SCALE;  end
			OP_FPMUL: begin mul_a = fp_q;              mul_b = a34;         end
			default:  begin mul_a = '0;                mul_b = '0;          end
		endcase
	end

	assign wsum = MUL_W'(v_q) + K_OFFSET;
	assign tneg = -$signed(p24[WIDE_W-1:0]);
	assign num  = s4_q + WIDE_W'(s3_q) * 40'sd20 + WIDE_W'(s2_q) * 40'sd190
		+ WIDE_W'(s_q) * 40'sd640 + NUM_C0;
	assign den  = s4_q - WIDE_W'(s3_q) * 40'sd15 + WIDE_W'(s2_q) * 40'sd180
		- WIDE_W'(s_q) * 40'sd840 + DEN_C0;
	assign mag  = $signed(p24[MUL_W-1:0]);
	assign bp   = $signed(p16[WIDE_W-1:0]) + Q24_ONE;
	assign ysum = WIDE_W'(y24) - WIDE_W'(quo) + 40'sd8;

	assign div_start    = (cmd.op == OP_DIV1) || (cmd.op == OP_DIV2);
	assign div_dividend = (cmd.op == OP_DIV1) ? (DIVD_W'(num_q) <<< 24)
		: (DIVD_W'(bigf_q) <<< 24);
	assign div_divisor  = (cmd.op == OP_DIV1) ? DIVS_W'(den_q) : DIVS_W'(bigfp_q);

	zcns_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_q[0] <= '0;
			y_q[1] <= '0;
		end else if (cmd.op == OP_Y) begin
			if (cmd.ch) y_q[1] <= sat24(ysum >>> 4);
			else        y_q[0] <= sat24(ysum >>> 4);
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				xl_q <= sample_left;
				xr_q <= sample_right;
				a_q  <= (drive_coeff > A_MAX) ? A_MAX : drive_coeff;
			end
			OP_UMUL, OP_LMUL, OP_TMUL, OP_S2MUL, OP_S3MUL, OP_S4MUL, OP_KMUL, OP_FPMUL:
				prod_q <= mul_a * mul_b;
			OP_U:    u_q <= sat32(WIDE_W'(x24) + $signed(p16[WIDE_W-1:0]));
			OP_V:    v_q <= sat32((WIDE_W'(u_q) <<< 3) + (WIDE_W'(u_q) <<< 1));
			OP_LIN: begin
				f_q  <= mag;
				fp_q <= K_SLOPE;
			end
			OP_W:    w_q  <= wsum[MUL_W-1] ? -wsum : wsum;
			OP_T:    s_q  <= MUL_W'(tneg >>> 8);
			OP_S2:   s2_q <= MUL_W'(p16);
			OP_S3:   s3_q <= MUL_W'(p16);
			OP_S4:   s4_q <= WIDE_W'(p16);
			OP_ND: begin
				num_q <= num;
				den_q <= (den < 40'sd1) ? 40'sd1 : den;
			end
			OP_F: begin
				f_q  <= v_q[31] ? -mag : mag;
				fp_q <= MUL_W'(quo) + K_BETA_EXP_10;
			end
			OP_FP: begin
				bigfp_q <= (bp < 40'sd1) ? 40'sd1 : bp;
				bigf_q  <= f_q + MUL_W'(y24);
			end
			OP_OUT: begin
				outl_q <= negsat24(y_q[0]);
				outr_q <= negsat24(y_q[1]);
			end
			default: ;
		endcase
	end

	assign sts.linear   = (v_q < K_LIMIT) && (v_q > -K_LIMIT);
	assign sts.div_busy = div_busy;
	assign out_left     = outl_q;
	assign out_right    = outr_q;
endmodule
`default_nettype wire

[rtl/zcns_ctrl.sv]
// sequencer for the solver: handshakes, iteration and channel counters, op issue
// uses zcns_pkg
`default_nettype none
module zcns_ctrl #(
	parameter int MAX_ITERATIONS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [zcns_pkg::ITER_W-1:0]   iterations,
	output zcns_pkg::dp_cmd_t                  cmd,
	input  wire zcns_pkg::dp_sts_t             sts
);
	import zcns_pkg::*;

	localparam int CW = $clog2(MAX_ITERATIONS + 1);

	typedef enum logic [24:0] {
		ST_IDLE   = 25'h0000001, ST_UMUL  = 25'h0000002, ST_U     = 25'h0000004,
		ST_V      = 25'h0000008, ST_SEL   = 25'h0000010, ST_LIN   = 25'h0000020,
		ST_TMUL   = 25'h0000040, ST_T     = 25'h0000080, ST_S2MUL = 25'h0000100,
		ST_S2     = 25'h0000200, ST_S3MUL = 25'h0000400, ST_S3    = 25'h0000800,
		ST_S4MUL  = 25'h0001000, ST_S4    = 25'h0002000, ST_ND    = 25'h0004000,
		ST_D1GO   = 25'h0008000, ST_D1WAIT = 25'h0010000, ST_KMUL = 25'h0020000,
		ST_F      = 25'h0040000, ST_FPMUL = 25'h0080000, ST_FP    = 25'h0100000,
		ST_D2GO   = 25'h0200000, ST_D2WAIT = 25'h0400000, ST_Y    = 25'h0800000,
		ST_OUT    = 25'h1000000
	} state_t;

	state_t          state_q, state_d;
	op_t             op;
	logic [ITER_W-1:0] iter_q;
	logic [CW-1:0]   steps, it_q;
	logic            ch_q;
	logic            last_it;
	logic            out_valid_q;
	logic            out_free;

	always_comb begin
		if (iter_q == '0) steps = CW'(1);
		else if (int'(iter_q) > MAX_ITERATIONS) steps = CW'(MAX_ITERATIONS);
		else steps = CW'(iter_q);
	end

	assign last_it  = (it_q == steps - 1'b1);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		op      = OP_NOP;
		unique case (state_q)
			ST_IDLE: if (in_valid) begin
				op = OP_LOAD;
				state_d = ST_UMUL;
			end
			ST_UMUL:  begin op = OP_UMUL;  state_d = ST_U;     end
			ST_U:     begin op = OP_U;     state_d = ST_V;     end
			ST_V:     begin op = OP_V;     state_d = ST_SEL;   end
			ST_SEL: begin
				if (sts.linear) begin
					op = OP_LMUL;
					state_d = ST_LIN;
				end else begin
					op = OP_W;
					state_d = ST_TMUL;
				end
			end
			ST_LIN:   begin op = OP_LIN;   state_d = ST_FPMUL; end
			ST_TMUL:  begin op = OP_TMUL;  state_d = ST_T;     end
			ST_T:     begin op = OP_T;     state_d = ST_S2MUL; end
			ST_S2MUL: begin op = OP_S2MUL; state_d = ST_S2;    end
			ST_S2:    begin op = OP_S2;    state_d = ST_S3MUL; end
			ST_S3MUL: begin op = OP_S3MUL; state_d = ST_S3;    end
			ST_S3:    begin op = OP_S3;    state_d = ST_S4MUL; end
			ST_S4MUL: begin op = OP_S4MUL; state_d = ST_S4;    end
			ST_S4:    begin op = OP_S4;    state_d = ST_ND;    end
			ST_ND:    begin op = OP_ND;    state_d = ST_D1GO;  end
			ST_D1GO:  begin op = OP_DIV1;  state_d = ST_D1WAIT; end
			ST_D1WAIT: if (!sts.div_busy) state_d = ST_KMUL;
			ST_KMUL:  begin op = OP_KMUL;  state_d = ST_F;     end
			ST_F:     begin op = OP_F;     state_d = ST_FPMUL; end
			ST_FPMUL: begin op = OP_FPMUL; state_d = ST_FP;    end
			ST_FP:    begin op = OP_FP;    state_d = ST_D2GO;  end
			ST_D2GO:  begin op = OP_DIV2;  state_d = ST_D2WAIT; end
			ST_D2WAIT: if (!sts.div_busy) state_d = ST_Y;
			ST_Y: begin
				op = OP_Y;
				state_d = (last_it && ch_q) ? ST_OUT : ST_UMUL;
			end
			ST_OUT: if (out_free) begin
				op = OP_OUT;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= ITER_RESET;
			it_q        <= '0;
			ch_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) iter_q <= iterations;
			if (op == OP_LOAD) begin
				it_q <= '0;
				ch_q <= 1'b0;
			end else if (op == OP_Y) begin
				if (last_it) begin
					it_q <= '0;
					ch_q <= 1'b1;
				end else begin
					it_q <= it_q + 1'b1;
				end
			end
			if (op == OP_OUT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign cmd.op    = op;
	assign cmd.ch    = ch_q;
endmodule
`default_nettype wire

[rtl/zener_clipper_newton_solver.sv]
// work per item: 2 * N iterations, each on the linear or the clipping branch (a divide wait
// ends without the bit steps when its quotient saturates), then the result register is
// loaded; N is the iterations register clamped to 1..MAX_ITERATIONS
// flow: one item at a time; the 31-step radix-2 divider serves twice per clipping iteration
// and once per linear one; the result register lets the next item in while one waits
// reset: asynchronous, clears estimates to zero, iterations to 8, no result pending
`default_nettype none
module zener_clipper_newton_solver #(
	parameter int MAX_ITERATIONS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [zcns_pkg::SAMPLE_W-1:0]  sample_left,
	input  wire logic signed [zcns_pkg::SAMPLE_W-1:0]  sample_right,
	input  wire logic        [zcns_pkg::COEFF_W-1:0]   drive_coeff,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [zcns_pkg::SAMPLE_W-1:0]       out_left,
	output logic signed [zcns_pkg::SAMPLE_W-1:0]       out_right,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic        [zcns_pkg::ITER_W-1:0]    iterations
);
	import zcns_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	zcns_ctrl #(
		.MAX_ITERATIONS (MAX_ITERATIONS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.iterations (iterations),
		.cmd        (cmd),
		.sts        (sts)
	);

	zcns_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.sample_left  (sample_left),
		.sample_right (sample_right),
		.drive_coeff  (drive_coeff),
		.out_left     (out_left),
		.out_right    (out_right)
	);
endmodule
`default_nettype wire

[rtl/zcns_checker.sv]
// port-level checks for the solver top level, attached by bind
// uses assert_macros.svh and zcns_pkg
`default_nettype none
`include "assert_macros.svh"
module zcns_checker (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  in_valid,
	input wire logic                                  in_ready,
	input wire logic                                  out_valid,
	input wire logic                                  out_ready,
	input wire logic signed [zcns_pkg::SAMPLE_W-1:0]  out_left,
	input wire logic signed [zcns_pkg::SAMPLE_W-1:0]  out_right,
	input wire logic                                  cfg_ready
);
	import zcns_pkg::*;

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_left) && $stable(out_right), "stalled result changed")
	`ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready,
		"second item taken while one is in work")
	`ASSERT_IMPLIES(a_cfg_open, clk, arst_n, 1'b1, cfg_ready, "config port not ready")
	`ASSERT_IMPLIES(a_neg_sat, clk, arst_n, out_valid,
		(out_left != 24'sh800000) && (out_right != 24'sh800000), "negation not saturated")
endmodule

bind zener_clipper_newton_solver zcns_checker u_chk (.*);
`default_nettype wire

[tb/sv/testbench.sv]
// testbench for the stereo zener clipper newton solver: a directed table, then random items
// per iterations setting, checked item by item against a predictor built into this file or a typed table value
// depends on rtl/zcns_pkg.sv and rtl/zener_clipper_newton_solver.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import zcns_pkg::*;

	localparam int MAX_ITER = 16;
	localparam int CYCLE_LIMIT = 6000000;
	localparam int DRAIN_CYCLES = 3000;
	localparam int HOLD_CYCLES = 20000;

	typedef struct {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
	} stereo_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] x_l;
		logic signed [SAMPLE_W-1:0] x_r;
		logic [COEFF_W-1:0]         drive;
		bit                         typed;
		logic signed [SAMPLE_W-1:0] y_l;
		logic signed [SAMPLE_W-1:0] y_r;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [SAMPLE_W-1:0] sample_left = '0;
	logic signed [SAMPLE_W-1:0] sample_right = '0;
	logic [COEFF_W-1:0] drive_coeff = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] out_left;
	logic signed [SAMPLE_W-1:0] out_right;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ITER_W-1:0] iterations = ITER_RESET;

	zener_clipper_newton_solver #(.MAX_ITERATIONS(MAX_ITER)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.sample_left(sample_left), .sample_right(sample_right), .drive_coeff(drive_coeff),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_left(out_left), .out_right(out_right),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .iterations(iterations)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	stereo_t expected_out[$];
	longint est_l = 0, est_r = 0;
	logic [ITER_W-1:0] iter_reg = ITER_RESET;
	int mismatches = 0;
	int results_seen = 0;
	int cycles = 0;
	int send_gap_max = 8;
	int recv_gap_max = 8;

	function automatic longint clamp(longint x, longint lo, longint hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function automatic longint exp_rational(longint t);
		longint s, s2, s3, s4, num, den;
		s = t >>> 8;
		s2 = (s * s) >>> 16;
		s3 = (s2 * s) >>> 16;
		s4 = (s2 * s2) >>> 16;
		num = s4 + 20 * s3 + 190 * s2 + 640 * s + 64'sd1680 * 64'sd65536;
		den = s4 - 15 * s3 + 180 * s2 - 840 * s + 64'sd2180 * 64'sd65536;
		if (den < 1) den = 1;
		return clamp((num * 64'sd16777216) / den, -64'sd2147483648, 64'sd2147483647);
	endfunction

	function automatic longint newton_solve(longint x, longint y, longint a, int steps);
		longint x24, y24, u, v, av, f, fp, bf, bfp, delta, w, e, mag;
		x24 = x * 16;
		for (int i = 0; i < steps; i++) begin
			y24 = y * 16;
			u = clamp(x24 + ((a * y24) >>> 16), -64'sd2147483648, 64'sd2147483647);
			v = clamp(10 * u, -64'sd2147483648, 64'sd2147483647);
			av = v < 0 ? -v : v;
			if (av < 64'sd125829120) begin
				f = (v * 64'sd1660944) >>> 24;
				fp = 64'sd16609444;
			end else begin
				w = v + 64'sd3727243;
				if (w < 0) w = -w;
				e = exp_rational(-((64'sd2527337 * w) >>> 24));
				mag = ((64'sd137573171 - e) * 64'sd1660944) >>> 24;
				f = v < 0 ? -mag : mag;
				fp = e + 64'sd252734;
			end
			bf = f + y24;
			bfp = ((fp * a) >>> 16) + 64'sd16777216;
			if (bfp < 1) bfp = 1;
			delta = (bf * 64'sd16777216) / bfp;
			y = clamp((y24 - delta + 8) >>> 4, -64'sd8388608, 64'sd8388607);
		end
		return y;
	endfunction

	function automatic stereo_t predict_clip(logic signed [SAMPLE_W-1:0] xl,
			logic signed [SAMPLE_W-1:0] xr, logic [COEFF_W-1:0] d);
		longint a;
		int steps;
		stereo_t r;
		a = d > A_MAX ? 65536 : longint'(d);
		steps = iter_reg < 1 ? 1 : (iter_reg > MAX_ITER ? MAX_ITER : int'(iter_reg));
		est_l = newton_solve(longint'(xl), est_l, a, steps);
		est_r = newton_solve(longint'(xr), est_r, a, steps);
		r.left = SAMPLE_W'(clamp(-est_l, -64'sd8388608, 64'sd8388607));
		r.right = SAMPLE_W'(clamp(-est_r, -64'sd8388608, 64'sd8388607));
		return r;
	endfunction

	task automatic send_sample(logic signed [SAMPLE_W-1:0] xl, logic signed [SAMPLE_W-1:0] xr,
			logic [COEFF_W-1:0] d, bit typed, stereo_t typed_out);
		int gap;
		stereo_t p;
		gap = $urandom_range(send_gap_max, 0);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_left = xl;
		sample_right = xr;
		drive_coeff = d;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		p = predict_clip(xl, xr, d);
		expected_out.push_back(typed ? typed_out : p);
		@(negedge clk);
	endtask

	task automatic write_iterations(logic [ITER_W-1:0] val);
		in_valid = 1'b0;
		while (expected_out.size() != 0) @(negedge clk);
		iterations = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		iter_reg = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] rand_sample(bit full);
		logic signed [SAMPLE_W-1:0] s;
		if (full) s = SAMPLE_W'($urandom);
		else s = SAMPLE_W'($signed($urandom_range(1572864, 0)) - 786432);
		return s;
	endfunction

	function automatic logic [COEFF_W-1:0] rand_drive();
		int k;
		k = $urandom_range(9, 0);
		if (k == 0) return COEFF_W'($urandom_range(131071, 0));
		else if (k == 1) return A_MAX;
		else if (k == 2) return '0;
		else return COEFF_W'($urandom_range(65536, 0));
	endfunction

	row_t dir_rows[] = '{
		'{24'sd0, 24'sd0, 17'd0, 1'b1, 24'sd0, 24'sd0},
		'{24'sd0, 24'sd0, 17'd65536, 1'b1, 24'sd0, 24'sd0},
		'{24'sh7fffff, 24'sh800000, 17'd0, 1'b0, 24'sd0, 24'sd0},
		'{24'sh800000, 24'sh7fffff, 17'd65536, 1'b0, 24'sd0, 24'sd0},
		'{24'sh7fffff, 24'sh7fffff, 17'd131071, 1'b0, 24'sd0, 24'sd0},
		'{24'sh800000, 24'sh800000, 17'd65537, 1'b0, 24'sd0, 24'sd0},
		'{24'sd1, -24'sd1, 17'd1, 1'b0, 24'sd0, 24'sd0},
		'{24'sd786431, -24'sd786432, 17'd32768, 1'b0, 24'sd0, 24'sd0},
		'{24'sd786432, -24'sd786433, 17'd32768, 1'b0, 24'sd0, 24'sd0},
		'{24'sd1048576, -24'sd1048576, 17'd65535, 1'b0, 24'sd0, 24'sd0},
		'{24'sd4194304, -24'sd4194304, 17'd49152, 1'b0, 24'sd0, 24'sd0},
		'{24'sd300000, 24'sd700000, 17'd0, 1'b0, 24'sd0, 24'sd0},
		'{-24'sd8000000, 24'sd8000000, 17'd100000, 1'b0, 24'sd0, 24'sd0},
		'{24'sh555555, 24'shaaaaaa, 17'h15555, 1'b0, 24'sd0, 24'sd0},
		'{24'shaaaaaa, 24'sh555555, 17'h0aaaa, 1'b0, 24'sd0, 24'sd0},
		'{24'sd0, 24'sd0, 17'd65536, 1'b0, 24'sd0, 24'sd0}
	};

	int phase_iter[10] = '{1, 16, 0, 31, 2, 12, 3, 8, 5, 1};
	int phase_count[10] = '{200, 40, 150, 40, 200, 60, 200, 100, 150, 30};

	initial begin
		stereo_t t;
		bit full;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (dir_rows[i]) begin
			t.left = dir_rows[i].y_l;
			t.right = dir_rows[i].y_r;
			send_sample(dir_rows[i].x_l, dir_rows[i].x_r, dir_rows[i].drive,
				dir_rows[i].typed, t);
		end
		for (int ph = 0; ph < 10; ph++) begin
			write_iterations(ITER_W'(phase_iter[ph]));
			send_gap_max = (ph % 3 == 2) ? 0 : 8;
			recv_gap_max = (ph % 4 == 3) ? 0 : 8;
			for (int n = 0; n < phase_count[ph]; n++) begin
				full = $urandom_range(3, 0) == 0;
				send_sample(rand_sample(full), rand_sample(full), rand_drive(), 1'b0, t);
			end
		end
		in_valid = 1'b0;
		while (expected_out.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0) $display("testbench: done, clean");
		else $display("testbench: done, errors");
		$finish;
	end

	initial begin
		int gap;
		bit held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && results_seen >= 60) begin
				held = 1'b1;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			gap = $urandom_range(recv_gap_max, 0);
			if (gap > 0) begin
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		stereo_t e;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
		if (out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (expected_out.size() == 0) begin
				if (mismatches < 10) $display("unexpected item: %0d %0d", out_left, out_right);
				mismatches <= mismatches + 1;
			end else begin
				e = expected_out.pop_front();
				if (e.left !== out_left || e.right !== out_right) begin
					if (mismatches < 10)
						$display("mismatch item %0d: expected %0d %0d, got %0d %0d",
							results_seen, e.left, e.right, out_left, out_right);
					mismatches <= mismatches + 1;
				end
			end
		end
	end

endmodule
`default_nettype wire
